@@ rtl/page_frame_allocator_macros.svh @@
// Assertion macros shared by the page frame allocator RTL.
`ifndef PAGE_FRAME_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define PFA_ASSERT_SAME(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PFA_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pfa_pkg.sv @@
// Package: constants, codes and types of the page frame allocator.
`default_nettype none
package pfa_pkg;

    localparam int NUM_PAGES  = 512;
    localparam int NUM_PROCS  = 16;
    localparam int PAGE_BYTES = 4096;

    localparam int PAGE_W   = $clog2(NUM_PAGES);
    localparam int OFFSET_W = $clog2(PAGE_BYTES);
    localparam int OWNER_W  = 5;
    localparam int COUNT_W  = 7;
    localparam int SUCC_W   = 4;
    localparam int ADDR_W   = 22;
    localparam int ADDR_LIMIT = NUM_PAGES * PAGE_BYTES;

    localparam logic [PAGE_W-1:0]  PAGE_LAST = PAGE_W'(NUM_PAGES - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic signed [OWNER_W-1:0] PO_FREE = '0;

    typedef enum logic [2:0] {
        OP_ALLOC_ANY = 3'd0,
        OP_ALLOC_AT  = 3'd1,
        OP_ADD_REF   = 3'd2,
        OP_RELEASE   = 3'd3,
        OP_READ      = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NOFREE  = 2'd1,
        STAT_BADADDR = 2'd2,
        STAT_USED    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_LOOK,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic signed [OWNER_W-1:0] owner;
        logic [COUNT_W-1:0]        count;
    } entry_t;

    typedef struct packed {
        logic   hit;
        logic   wr;
        entry_t entry;
    } upd_t;

endpackage
`default_nettype wire

@@ rtl/pfa_store.sv @@
// Page table store: one write port, one registered read port.
`default_nettype none
module pfa_store (
    input  wire logic                       aclk,
    input  wire logic                       we,
    input  wire logic [pfa_pkg::PAGE_W-1:0] waddr,
    input  wire pfa_pkg::entry_t            wdata,
    input  wire logic [pfa_pkg::PAGE_W-1:0] raddr,
    output pfa_pkg::entry_t                 rdata
);
    import pfa_pkg::*;

    entry_t mem [NUM_PAGES];
    entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ rtl/pfa_entry_unit.sv @@
// Shared entry unit: match test and updated entry for every operation.
`default_nettype none
module pfa_entry_unit (
    input  wire pfa_pkg::op_t                  op,
    input  wire logic signed [pfa_pkg::OWNER_W-1:0] who,
    input  wire logic [pfa_pkg::SUCC_W-1:0]    succ,
    input  wire pfa_pkg::entry_t               cur,
    output pfa_pkg::upd_t                      upd
);
    import pfa_pkg::*;

    logic frees;

    assign frees = (succ == '0) || (int'(succ) >= NUM_PROCS);

    always_comb begin
        upd.hit   = 1'b0;
        upd.wr    = 1'b0;
        upd.entry = cur;
        unique case (op)
            OP_ALLOC_ANY: begin
                upd.hit = (cur.owner == PO_FREE) && (cur.count == '0);
                upd.wr  = upd.hit;
                if (upd.hit) begin
                    upd.entry.owner = who;
                    upd.entry.count = COUNT_W'(1);
                end
            end
            OP_ALLOC_AT: begin
                upd.hit = (cur.count == '0);
                upd.wr  = upd.hit;
                if (upd.hit) begin
                    upd.entry.owner = who;
                    upd.entry.count = COUNT_W'(1);
                end
            end
            OP_ADD_REF: begin
                upd.hit = 1'b1;
                upd.wr  = (cur.count != COUNT_MAX);
                if (cur.count != COUNT_MAX) begin
                    upd.entry.count = cur.count + COUNT_W'(1);
                end
            end
            OP_RELEASE: begin
                upd.hit = (cur.owner == who);
                upd.wr  = upd.hit;
                if (cur.count > COUNT_W'(1) && !frees) begin
                    upd.entry.owner = signed'({1'b0, succ});
                    upd.entry.count = cur.count - COUNT_W'(1);
                end else begin
                    upd.entry.owner = PO_FREE;
                    upd.entry.count = '0;
                end
            end
            OP_READ: begin
                upd.hit = 1'b1;
            end
            default: begin
                upd.hit = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/page_frame_allocator.sv @@
// Top level: page frame allocator sequencer, store and result register.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: op, owner, address, page, successor
//  m_      | out | m_tvalid/m_tready  | m_tdata: status, page, owner, count
//
// release_owner walks the whole table one page per cycle; alloc_any stops at
// the first free page. After reset a clearing pass writes NUM_PAGES entries,
// one per cycle, before the first item is taken. The store's single read port
// sets the sweep speed. A result waits in the output register while m_tready
// is low.
`default_nettype none
`include "page_frame_allocator_macros.svh"
module page_frame_allocator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    // [2:0] operation, [7:3] owner, [29:8] page_address, [38:30] page_number,
    // [42:39] successor_owner
    input  wire logic [47:0] s_tdata,
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    // [1:0] status, [10:2] result_page, [15:11] entry_owner, [22:16] entry_refcount
    output      logic [23:0] m_tdata
);
    import pfa_pkg::*;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic signed [OWNER_W-1:0] who_reg, who_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [PAGE_W-1:0] pn_reg, pn_next;
    logic [SUCC_W-1:0] succ_reg, succ_next;

    logic [PAGE_W-1:0] idx_reg, idx_next;
    logic [PAGE_W-1:0] chk_idx_reg, chk_idx_next;
    logic              chk_valid_reg, chk_valid_next;

    status_t           res_status_reg, res_status_next;
    logic [PAGE_W-1:0] res_page_reg, res_page_next;
    entry_t            res_entry_reg, res_entry_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [23:0]       m_data_reg, m_data_next;

    logic              mem_we;
    logic [PAGE_W-1:0] mem_waddr;
    entry_t            mem_wdata;
    logic [PAGE_W-1:0] mem_raddr;
    entry_t            mem_rdata;
    upd_t              upd;

    logic              at_bad;
    logic [PAGE_W-1:0] at_page;
    logic              pn_bad;

    pfa_store u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pfa_entry_unit u_entry (
        .op   (op_reg),
        .who  (who_reg),
        .succ (succ_reg),
        .cur  (mem_rdata),
        .upd  (upd)
    );

    assign at_page = addr_reg[OFFSET_W +: PAGE_W];
    assign at_bad  = (addr_reg[OFFSET_W-1:0] != '0) || (int'(addr_reg) >= ADDR_LIMIT);
    assign pn_bad  = (int'(pn_reg) >= NUM_PAGES);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            chk_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            chk_valid_reg <= chk_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        who_reg        <= who_next;
        addr_reg       <= addr_next;
        pn_reg         <= pn_next;
        succ_reg       <= succ_next;
        chk_idx_reg    <= chk_idx_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        res_entry_reg  <= res_entry_next;
        m_data_reg     <= m_data_next;
    end

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        who_next        = who_reg;
        addr_next       = addr_reg;
        pn_next         = pn_reg;
        succ_next       = succ_reg;
        idx_next        = idx_reg;
        chk_idx_next    = chk_idx_reg;
        chk_valid_next  = 1'b0;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        res_entry_next  = res_entry_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_data_next     = m_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = chk_idx_reg;
        mem_wdata       = upd.entry;
        mem_raddr       = idx_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = '0;
                idx_next  = idx_reg + PAGE_W'(1);
                if (idx_reg == PAGE_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = op_t'(s_tdata[2:0]);
                    who_next   = signed'(s_tdata[7:3]);
                    addr_next  = s_tdata[29:8];
                    pn_next    = s_tdata[38:30];
                    succ_next  = s_tdata[42:39];
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                res_status_next = STAT_OK;
                res_page_next   = '0;
                res_entry_next  = '0;
                case (op_reg) inside
                    OP_ALLOC_ANY, OP_RELEASE: begin
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end
                    OP_ALLOC_AT: begin
                        if (at_bad) begin
                            res_status_next = STAT_BADADDR;
                            res_page_next   = at_page;
                            state_next      = ST_RESP;
                        end else begin
                            mem_raddr    = at_page;
                            chk_idx_next = at_page;
                            state_next   = ST_LOOK;
                        end
                    end
                    OP_ADD_REF, OP_READ: begin
                        if (pn_bad) begin
                            res_status_next = STAT_BADADDR;
                            res_page_next   = pn_reg;
                            state_next      = ST_RESP;
                        end else begin
                            mem_raddr    = pn_reg;
                            chk_idx_next = pn_reg;
                            state_next   = ST_LOOK;
                        end
                    end
                    default: begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_SCAN: begin
                mem_raddr      = idx_reg;
                idx_next       = idx_reg + PAGE_W'(1);
                chk_idx_next   = idx_reg;
                chk_valid_next = 1'b1;
                if (chk_valid_reg) begin
                    mem_we = upd.wr;
                    if (op_reg == OP_ALLOC_ANY && upd.hit) begin
                        res_status_next = STAT_OK;
                        res_page_next   = chk_idx_reg;
                        res_entry_next  = upd.entry;
                        chk_valid_next  = 1'b0;
                        state_next      = ST_RESP;
                    end else if (chk_idx_reg == PAGE_LAST) begin
                        res_status_next = (op_reg == OP_ALLOC_ANY) ? STAT_NOFREE : STAT_OK;
                        res_page_next   = '0;
                        res_entry_next  = '0;
                        chk_valid_next  = 1'b0;
                        state_next      = ST_RESP;
                    end
                end
            end
            ST_LOOK: begin
                mem_we          = upd.wr;
                res_status_next = upd.hit ? STAT_OK : STAT_USED;
                res_page_next   = chk_idx_reg;
                res_entry_next  = upd.entry;
                state_next      = ST_RESP;
            end
            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = {1'b0, res_entry_reg.count, res_entry_reg.owner,
                                     res_page_reg, res_status_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `PFA_ASSERT_SAME(a_clear_not_ready, aclk, aresetn, state_reg == ST_CLEAR, !s_tready,
                     "item accepted during clearing pass")
    `PFA_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_tvalid && s_tready,
                     state_reg == ST_PREP && !s_tready,
                     "block ready right after accepting an item")
    `PFA_ASSERT_NEXT(a_alloc_stops, aclk, aresetn,
                     state_reg == ST_SCAN && op_reg == OP_ALLOC_ANY && mem_we,
                     state_reg == ST_RESP, "alloc_any scan went on after claiming a page")
    `PFA_ASSERT_SAME(a_read_no_write, aclk, aresetn, state_reg == ST_LOOK && op_reg == OP_READ,
                     !mem_we, "read operation wrote the store")

endmodule
`default_nettype wire
